// ===== hw/rtl/ccwc_pkg.sv =====
package ccwc_pkg;

    // Field widths fixed by the interface
    localparam int COIN_W   = 10;
    localparam int AMOUNT_W = 10;
    localparam int WAYS_W   = 64;

    // Configuration port
    localparam int NUM_REGS   = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // Defaults for the top-level parameters
    localparam int MAX_AMOUNT_DEF = 1023;
    localparam int NUM_COINS_DEF  = 8;

    typedef logic [COIN_W-1:0] coin_t;
    typedef coin_t [NUM_REGS-1:0] coin_array_t;

    // Denominations after reset
    localparam coin_array_t COIN_RESET = {
        coin_t'(200), coin_t'(100), coin_t'(50), coin_t'(20),
        coin_t'(10),  coin_t'(5),   coin_t'(2),  coin_t'(1)
    };

    // Control for one read-modify-write step of the table sweep
    typedef struct packed {
        logic valid;   // a step is issued this cycle
        logic first;   // first pass: the old entry is taken as 1 at zero, else 0
        logic addend;  // add the entry one coin below
        logic last;    // final step of the query: its sum is the result
        logic reject;  // amount out of range: report zero
    } step_t;

endpackage

// ===== hw/rtl/coin_change_way_counter.sv =====
// Counts the unordered combinations of up to eight configured coin values
// that add up to an amount. Raise start for one cycle while busy is low; the
// result appears on ways and saturated for exactly one cycle, marked by done,
// and the receiver cannot stall it. Each query rebuilds a ways-per-amount
// table in on-chip memory, one read-modify-write step per clock: a first
// sweep over amounts 0 to amount, then one sweep from each later coin that is
// non-zero and not above the amount up to the amount. done is registered
// from the last step as it leaves the read stage, and busy falls in that
// same cycle, so the next query may start there. An amount above MAX_AMOUNT
// returns zero via the reject and drain states. The memory port rate of one
// step per clock sets the query time. The user must write denominations
// through the APB port only while busy is low; the block does not enforce it.
module coin_change_way_counter #(
    parameter int MAX_AMOUNT = ccwc_pkg::MAX_AMOUNT_DEF,
    parameter int NUM_COINS  = ccwc_pkg::NUM_COINS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [ccwc_pkg::AMOUNT_W-1:0]        amount,
    output logic                                 done,
    output logic [ccwc_pkg::WAYS_W-1:0]          ways,
    output logic                                 saturated,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ccwc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [ccwc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [ccwc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    localparam int AW = $clog2(MAX_AMOUNT + 1);

    ccwc_pkg::coin_array_t coins;
    ccwc_pkg::step_t       step;
    logic [AW-1:0]         addr_hi;
    logic [AW-1:0]         addr_lo;

    // Denomination registers
    ccwc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coins   (coins)
    );

    // Sweep sequencer
    ccwc_seq #(
        .MAX_AMOUNT (MAX_AMOUNT),
        .NUM_COINS  (NUM_COINS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .amount  (amount),
        .coins   (coins),
        .busy    (busy),
        .step    (step),
        .addr_hi (addr_hi),
        .addr_lo (addr_lo)
    );

    // Table memory and accumulate stage
    ccwc_table #(
        .MAX_AMOUNT (MAX_AMOUNT)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .addr_hi   (addr_hi),
        .addr_lo   (addr_lo),
        .ways      (ways),
        .saturated (saturated),
        .done      (done)
    );

endmodule

// ===== hw/rtl/ccwc_regs.sv =====
module ccwc_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ccwc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ccwc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ccwc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output ccwc_pkg::coin_array_t               coins
);

    logic [2:0]                   index;
    ccwc_pkg::coin_array_t        coins_reg;
    ccwc_pkg::coin_array_t        coins_next;

    // Registers sit on word boundaries
    assign index  = paddr[4:2];
    assign pready = 1'b1;
    assign coins  = coins_reg;

    // Write decode: a transaction completes in the access cycle
    always_comb
    begin
        coins_next = coins_reg;
        if (psel && penable && pwrite)
        begin
            coins_next[index] = pwdata[ccwc_pkg::COIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coins_reg <= ccwc_pkg::COIN_RESET;
        end
        else
        begin
            coins_reg <= coins_next;
        end
    end

    // Read data is the selected denomination, zero-extended
    assign prdata = ccwc_pkg::APB_DATA_W'(coins_reg[index]);

endmodule

// ===== hw/rtl/ccwc_seq.sv =====
module ccwc_seq #(
    parameter int MAX_AMOUNT = ccwc_pkg::MAX_AMOUNT_DEF,
    parameter int NUM_COINS  = ccwc_pkg::NUM_COINS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [ccwc_pkg::AMOUNT_W-1:0]        amount,
    input  ccwc_pkg::coin_array_t                coins,
    output logic                                 busy,
    output ccwc_pkg::step_t                      step,
    output logic [$clog2(MAX_AMOUNT+1)-1:0]      addr_hi,
    output logic [$clog2(MAX_AMOUNT+1)-1:0]      addr_lo
);

    localparam int AW  = $clog2(MAX_AMOUNT + 1);
    localparam int CIW = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_REJECT,
        ST_DRAIN
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        amt_reg, amt_next;
    logic [AW-1:0]        a_reg, a_next;
    logic [AW-1:0]        coin_reg, coin_next;
    logic [CIW-1:0]       idx_reg, idx_next;
    logic [NUM_COINS-1:0] active_reg, active_next;

    logic [NUM_COINS-1:0] active_now;
    logic                 nxt_found;
    logic [CIW-1:0]       nxt_idx;
    logic                 pass_end;
    logic                 use_addend;

    // Coins that take part in this query: non-zero and not above the amount
    always_comb
    begin
        for (int i = 0; i < NUM_COINS; i++)
        begin
            active_now[i] = (coins[i] != '0) && (coins[i] <= amount);
        end
    end

    // Next active coin after the current pass, lowest index first
    always_comb
    begin
        nxt_found = 1'b0;
        nxt_idx   = '0;
        for (int i = NUM_COINS - 1; i > 0; i--)
        begin
            if (active_reg[i] && (CIW'(i) > idx_reg))
            begin
                nxt_found = 1'b1;
                nxt_idx   = CIW'(i);
            end
        end
    end

    assign pass_end   = (a_reg == amt_reg);
    assign use_addend = (idx_reg != '0) || (active_reg[0] && (a_reg >= coin_reg));

    // Step issued to the table this cycle
    always_comb
    begin
        step.valid  = (state_reg == ST_SWEEP);
        step.first  = (idx_reg == '0);
        step.addend = use_addend;
        step.last   = (state_reg == ST_SWEEP) && pass_end && !nxt_found;
        step.reject = (state_reg == ST_REJECT);
        addr_hi     = a_reg;
        addr_lo     = use_addend ? (a_reg - coin_reg) : '0;
    end

    assign busy = (state_reg != ST_IDLE);

    // Sweep sequencer: first pass from zero, later passes from their coin, rejects above MAX_AMOUNT
    always_comb
    begin
        state_next  = state_reg;
        amt_next    = amt_reg;
        a_next      = a_reg;
        coin_next   = coin_reg;
        idx_next    = idx_reg;
        active_next = active_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (32'(amount) > MAX_AMOUNT)
                    begin
                        state_next = ST_REJECT;
                    end
                    else
                    begin
                        state_next  = ST_SWEEP;
                        amt_next    = AW'(amount);
                        a_next      = '0;
                        idx_next    = '0;
                        coin_next   = AW'(coins[0]);
                        active_next = active_now;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (pass_end)
                begin
                    if (nxt_found)
                    begin
                        idx_next  = nxt_idx;
                        coin_next = AW'(coins[nxt_idx]);
                        a_next    = AW'(coins[nxt_idx]);
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    a_next = a_reg + 1'b1;
                end
            end
            ST_REJECT:
            begin
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            amt_reg    <= '0;
            a_reg      <= '0;
            coin_reg   <= '0;
            idx_reg    <= '0;
            active_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            amt_reg    <= amt_next;
            a_reg      <= a_next;
            coin_reg   <= coin_next;
            idx_reg    <= idx_next;
            active_reg <= active_next;
        end
    end

endmodule

// ===== hw/rtl/ccwc_table.sv =====
module ccwc_table #(
    parameter int MAX_AMOUNT = ccwc_pkg::MAX_AMOUNT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ccwc_pkg::step_t                      step,
    input  logic [$clog2(MAX_AMOUNT+1)-1:0]      addr_hi,
    input  logic [$clog2(MAX_AMOUNT+1)-1:0]      addr_lo,
    output logic [ccwc_pkg::WAYS_W-1:0]          ways,
    output logic                                 saturated,
    output logic                                 done
);

    localparam int AW    = $clog2(MAX_AMOUNT + 1);
    localparam int DEPTH = MAX_AMOUNT + 1;
    localparam int WW    = ccwc_pkg::WAYS_W;

    logic [WW-1:0]   mem [DEPTH];

    ccwc_pkg::step_t s1_step_reg;
    logic [AW-1:0]   s1_hi_reg;
    logic [AW-1:0]   s1_lo_reg;
    logic [WW-1:0]   rd_hi_reg;
    logic [WW-1:0]   rd_lo_reg;

    logic            lw_valid_reg;
    logic [AW-1:0]   lw_addr_reg;
    logic [WW-1:0]   lw_data_reg;

    logic            done_reg;
    logic [WW-1:0]   ways_reg;
    logic            sat_reg;

    logic [WW-1:0]   old_val;
    logic [WW-1:0]   add_val;
    logic [WW:0]     sum_wide;
    logic [WW-1:0]   sum;

    // Table memory: two registered reads, one write
    always_ff @(posedge clk)
    begin
        rd_hi_reg <= mem[addr_hi];
        rd_lo_reg <= mem[addr_lo];
        if (s1_step_reg.valid)
        begin
            mem[s1_hi_reg] <= sum;
        end
    end

    // Addresses travel alongside the read
    always_ff @(posedge clk)
    begin
        s1_hi_reg <= addr_hi;
        s1_lo_reg <= addr_lo;
    end

    // Operands; the write of the previous cycle is forwarded, since the
    // memory returned the old contents for an address written in that cycle
    always_comb
    begin
        if (s1_step_reg.first)
        begin
            old_val = (s1_hi_reg == '0) ? WW'(1) : '0;
        end
        else if (lw_valid_reg && (lw_addr_reg == s1_hi_reg))
        begin
            old_val = lw_data_reg;
        end
        else
        begin
            old_val = rd_hi_reg;
        end

        if (!s1_step_reg.addend)
        begin
            add_val = '0;
        end
        else if (lw_valid_reg && (lw_addr_reg == s1_lo_reg))
        begin
            add_val = lw_data_reg;
        end
        else
        begin
            add_val = rd_lo_reg;
        end
    end

    // Saturating add
    assign sum_wide = {1'b0, old_val} + {1'b0, add_val};
    assign sum      = sum_wide[WW] ? '1 : sum_wide[WW-1:0];

    // Control of the write stage and the forwarding record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_step_reg  <= '0;
            lw_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_step_reg  <= step;
            lw_valid_reg <= s1_step_reg.valid;
            done_reg     <= (s1_step_reg.valid && s1_step_reg.last) || s1_step_reg.reject;
        end
    end

    always_ff @(posedge clk)
    begin
        lw_addr_reg <= s1_hi_reg;
        lw_data_reg <= sum;
        ways_reg    <= s1_step_reg.reject ? '0 : sum;
        sat_reg     <= !s1_step_reg.reject && (sum == '1);
    end

    assign ways      = ways_reg;
    assign saturated = sat_reg;
    assign done      = done_reg;

endmodule

// ===== hw/rtl/ccwc_checker.sv =====
module ccwc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 done,
    input logic [ccwc_pkg::WAYS_W-1:0]          ways,
    input logic                                 saturated
);

    // An accepted transaction keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // busy falls exactly with the result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result");

    // A result is only delivered once the block is free again
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    // Two results never come back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe in two consecutive cycles");

    // The flag marks exactly the all-ones count
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (saturated == (ways == '1)))
        else $error("saturation flag disagrees with the count");

endmodule

bind coin_change_way_counter ccwc_checker u_ccwc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .ways      (ways),
    .saturated (saturated)
);
